// ===== sv/divider_and_reload_timer_top_assert.svh =====
// assertion macros for the divider and reload timer
// used by divider_and_reload_timer_top; expects clk and rst_n in scope
`ifndef DIVIDER_AND_RELOAD_TIMER_TOP_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DART_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// next-cycle implication, checked out of reset
`define DART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

// ===== sv/dart_pkg.sv =====
// shared types, codes and constants of the divider and reload timer
// no dependencies; used by dart_core and divider_and_reload_timer_top
`timescale 1ns / 1ps

package dart_pkg;

    localparam int ACCUM_W        = 16;
    localparam int COUNT_W        = 8;
    localparam int CYCLES_W       = 4;
    localparam int PERIOD_W       = 9;
    localparam int DIVIDER_PERIOD = 64;

    localparam logic [ACCUM_W-1:0] ACCUM_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_TIMER_ENABLE = 2'd0,
        CFG_PERIOD_SEL   = 2'd1,
        CFG_RELOAD_VALUE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        SEL_256 = 2'd0,
        SEL_4   = 2'd1,
        SEL_16  = 2'd2,
        SEL_64  = 2'd3
    } clk_sel_t;

    typedef struct packed
    {
        op_t                 op;
        logic [CYCLES_W-1:0] cycles;
        logic [COUNT_W-1:0]  load_value;
    } item_t;

    typedef struct packed
    {
        logic                overflow;
        logic [COUNT_W-1:0]  counter_value;
        logic [COUNT_W-1:0]  divider_value;
    } result_t;

    typedef struct packed
    {
        logic               timer_enable;
        clk_sel_t           period_sel;
        logic [COUNT_W-1:0] reload_value;
    } cfg_t;

    function automatic logic [PERIOD_W-1:0] period_of(input clk_sel_t sel);
        logic [PERIOD_W-1:0] p;
        unique case (sel)
            SEL_256: p = 9'd256;
            SEL_4:   p = 9'd4;
            SEL_16:  p = 9'd16;
            SEL_64:  p = 9'd64;
            default: p = 9'd256;
        endcase
        return p;
    endfunction

    // saturating add of a tick count into an accumulator
    function automatic logic [ACCUM_W-1:0] sat_add(input logic [ACCUM_W-1:0] acc,
                                                   input logic [CYCLES_W-1:0] cyc);
        logic [ACCUM_W:0] s;
        s = {1'b0, acc} + (ACCUM_W+1)'(cyc);
        return s[ACCUM_W] ? ACCUM_MAX : s[ACCUM_W-1:0];
    endfunction

endpackage

// ===== sv/dart_core.sv =====
// timer state and the per-item update: divider, counter accumulator, reload
// depends on dart_pkg
`timescale 1ns / 1ps

module dart_core
#(
    parameter int DIVIDER_PERIOD = dart_pkg::DIVIDER_PERIOD
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  dart_pkg::item_t          item,
    input  dart_pkg::cfg_t           cfg,
    output dart_pkg::result_t        result,
    output logic [dart_pkg::COUNT_W-1:0] counter_now
);

    logic [dart_pkg::ACCUM_W-1:0] divider_accum_reg, divider_accum_next;
    logic [dart_pkg::COUNT_W-1:0] divider_count_reg, divider_count_next;
    logic [dart_pkg::ACCUM_W-1:0] counter_accum_reg, counter_accum_next;
    logic [dart_pkg::COUNT_W-1:0] counter_reg, counter_next;

    logic [dart_pkg::ACCUM_W-1:0] div_sum;
    logic [dart_pkg::ACCUM_W-1:0] cnt_sum;
    logic [dart_pkg::ACCUM_W-1:0] period;
    logic                         ovf;

    always_comb
    begin
        div_sum = dart_pkg::sat_add(divider_accum_reg, item.cycles);
        cnt_sum = dart_pkg::sat_add(counter_accum_reg, item.cycles);
        period  = dart_pkg::ACCUM_W'(dart_pkg::period_of(cfg.period_sel));

        divider_accum_next = divider_accum_reg;
        divider_count_next = divider_count_reg;
        counter_accum_next = counter_accum_reg;
        counter_next       = counter_reg;
        ovf                = 1'b0;

        unique case (item.op)
            dart_pkg::OP_LOAD:
            begin
                counter_next = item.load_value;
            end
            default:
            begin
                divider_accum_next = div_sum;
                if (div_sum >= dart_pkg::ACCUM_W'(DIVIDER_PERIOD))
                begin
                    divider_accum_next = div_sum - dart_pkg::ACCUM_W'(DIVIDER_PERIOD);
                    divider_count_next = divider_count_reg + dart_pkg::COUNT_W'(1);
                end
                if (cfg.timer_enable)
                begin
                    counter_accum_next = cnt_sum;
                    if (cnt_sum >= period)
                    begin
                        counter_accum_next = cnt_sum - period;
                        if (counter_reg == dart_pkg::COUNT_MAX)
                        begin
                            counter_next = cfg.reload_value;
                            ovf          = 1'b1;
                        end
                        else
                        begin
                            counter_next = counter_reg + dart_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
        endcase

        result.divider_value = divider_count_next;
        result.counter_value = counter_next;
        result.overflow      = ovf;
    end

    assign counter_now = counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_accum_reg <= '0;
            divider_count_reg <= '0;
            counter_accum_reg <= '0;
            counter_reg       <= '0;
        end
        else if (step)
        begin
            divider_accum_reg <= divider_accum_next;
            divider_count_reg <= divider_count_next;
            counter_accum_reg <= counter_accum_next;
            counter_reg       <= counter_next;
        end
    end

endmodule

// ===== sv/divider_and_reload_timer_top.sv =====
// top level of the prescaled timer/counter with reload
// depends on dart_pkg, dart_core and divider_and_reload_timer_top_assert.svh
// usage
//   s_* carries one request per item: s_tuser is the op (tick or load),
//   s_tdata the cycle count and the load value. every request gives exactly
//   one result on m_*: divider counter, timer counter and overflow flag.
//   cfg_* writes timer_enable, the period select and reload_value by index;
//   it is always ready and should only be used while the block is idle.
// pipeline and throughput
//   a request is registered in the input stage, its result in the result register
//   that drives m_tvalid; one request is taken every cycle while m_tready is high,
//   as a single add and compare per accumulator sits between the two registers
// reset
//   rst_n clears the valid flags of both stages, all accumulators, both counters
//   and the configuration registers to zero (timer disabled, period 256).
// back-pressure
//   with m_tready low the result holds; one further request is held in the
//   input stage, after which s_tready drops until the result is taken
`timescale 1ns / 1ps
`include "divider_and_reload_timer_top_assert.svh"

module divider_and_reload_timer_top
#(
    parameter int DIVIDER_PERIOD = dart_pkg::DIVIDER_PERIOD
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dart_pkg::S_TDATA_W-1:0]    s_tdata,  // [3:0] cycles, [11:4] load_value
    input  logic                              s_tuser,  // [0] op

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] divider_value, [15:8] counter_value, [16] overflow
    output logic [dart_pkg::M_TDATA_W-1:0]    m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dart_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dart_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // configuration registers
    dart_pkg::cfg_t     cfg_reg;

    // input stage
    logic               in_valid_reg;
    dart_pkg::item_t    item_reg;
    dart_pkg::item_t    item_in;

    // result stage
    logic               out_valid_reg;
    dart_pkg::result_t  result_reg;
    dart_pkg::result_t  result_next;

    logic               advance;
    logic               s_accept;
    logic [dart_pkg::COUNT_W-1:0] counter_now;

    // input stage moves on when the result register is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign item_in.op         = dart_pkg::op_t'(s_tuser);
    assign item_in.cycles     = s_tdata[dart_pkg::CYCLES_W-1:0];
    assign item_in.load_value = s_tdata[dart_pkg::CYCLES_W +: dart_pkg::COUNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timer_enable <= 1'b0;
            cfg_reg.period_sel   <= dart_pkg::SEL_256;
            cfg_reg.reload_value <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dart_pkg::cfg_idx_t'(cfg_index))
                dart_pkg::CFG_TIMER_ENABLE: cfg_reg.timer_enable <= cfg_data[0];
                dart_pkg::CFG_PERIOD_SEL:
                    cfg_reg.period_sel <= dart_pkg::clk_sel_t'(cfg_data[1:0]);
                dart_pkg::CFG_RELOAD_VALUE: cfg_reg.reload_value <= cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg <= item_in;
        end
    end

    // timer state and the update for the item in the input stage
    dart_core
    #(
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    )
    u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .result      (result_next),
        .counter_now (counter_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dart_pkg::M_TDATA_W'(result_reg);

    // an overflow only ever comes from a counter sitting at its top value
    `DART_ASSERT_NOW(a_ovf_from_top, advance && result_next.overflow, counter_now == dart_pkg::COUNT_MAX)
    // a load request never reports an overflow
    `DART_ASSERT_NEXT(a_load_no_ovf, advance && (item_reg.op == dart_pkg::OP_LOAD), !result_reg.overflow)
    // an item leaving the input stage always lands in the result register
    `DART_ASSERT_NEXT(a_advance_lands, advance, out_valid_reg)

endmodule
